// ----- sv/volume_min_max_normalize_to_atlas_unit_defines.svh -----
// Assertion macros for the port checker of the normalizer block.
// Depends on nothing; expects clk_i and rst_ni in the using scope.
`ifndef VOLUME_MIN_MAX_NORMALIZE_TO_ATLAS_UNIT_DEFINES_SVH
`define VOLUME_MIN_MAX_NORMALIZE_TO_ATLAS_UNIT_DEFINES_SVH

// Same-cycle implication, checked while out of reset
`define VMMN_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked while out of reset
`define VMMN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/vmmn_pkg.sv -----
// Package of the volume min/max normalizer: widths, reset values, FSM state
// and the command/status structs between controller and datapath. No deps.
package vmmn_pkg;

  localparam int VAL_W      = 16;
  localparam int COORD_W    = 10;
  localparam int LEVEL_W    = 17;
  localparam int ADDR_W     = 30;
  localparam int DIM_W      = 11;
  localparam int TILE_W     = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int IN_DATA_W  = 48;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 48;

  // quotient bits per emit request, also covers the 10-bit slice divide
  localparam int DIV_STEPS  = 16;
  localparam int CNT_W      = 4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SLICE_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLICE_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TILES_PER_ROW = 2'd2;

  localparam int WIDTH_RESET  = 512;
  localparam int HEIGHT_RESET = 512;
  localparam int TILES_RESET  = 23;

  localparam logic signed [VAL_W-1:0] LOW_RESET  = 16'sh7FFF;
  localparam logic signed [VAL_W-1:0] HIGH_RESET = 16'sh8000;

  localparam logic [LEVEL_W-1:0] LEVEL_ONE  = 17'h10000;
  localparam logic [LEVEL_W-1:0] LEVEL_ZERO = 17'h00000;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL1,
    ST_MUL2
  } vmmn_state_e;

  typedef struct packed {
    logic measure;  // measure-pass request accepted
    logic load;     // emit-pass request accepted
    logic step;     // one divider step
    logic mul1;     // row and column products
    logic emit;     // final product into the output register
  } vmmn_cmd_t;

  typedef struct packed {
    logic out_free; // output register can take a result this cycle
  } vmmn_stat_t;

endpackage

// ----- sv/vmmn_ctrl.sv -----
// Controller of the normalizer: request sequencing and divider step count.
// Depends on vmmn_pkg.
module vmmn_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_func_i,
  output logic                  in_ready_o,
  input  vmmn_pkg::vmmn_stat_t  stat_i,
  output vmmn_pkg::vmmn_cmd_t   cmd_o
);

  vmmn_pkg::vmmn_state_e state_q, state_d;
  logic [vmmn_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic accept;
  logic last_step;

  assign in_ready_o = (state_q == vmmn_pkg::ST_IDLE);
  assign accept     = in_valid_i & in_ready_o;
  assign last_step  = (cnt_q == vmmn_pkg::CNT_W'(vmmn_pkg::DIV_STEPS - 1));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      vmmn_pkg::ST_IDLE: if (accept && in_func_i) state_d = vmmn_pkg::ST_DIV;
      vmmn_pkg::ST_DIV:  if (last_step) state_d = vmmn_pkg::ST_MUL1;
      vmmn_pkg::ST_MUL1: state_d = vmmn_pkg::ST_MUL2;
      vmmn_pkg::ST_MUL2: if (stat_i.out_free) state_d = vmmn_pkg::ST_IDLE;
      default:           state_d = vmmn_pkg::ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      vmmn_pkg::ST_IDLE: begin
        cmd_o.measure = accept & ~in_func_i;
        cmd_o.load    = accept & in_func_i;
      end
      vmmn_pkg::ST_DIV:  cmd_o.step = 1'b1;
      vmmn_pkg::ST_MUL1: cmd_o.mul1 = 1'b1;
      vmmn_pkg::ST_MUL2: cmd_o.emit = stat_i.out_free;
      default:           cmd_o = '0;
    endcase
  end

  // step counter runs only in the divide state
  always_comb begin
    cnt_d = '0;
    if (state_q == vmmn_pkg::ST_DIV) cnt_d = cnt_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= vmmn_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// ----- sv/vmmn_datapath.sv -----
// Datapath of the normalizer: registers, min/max tracking, two shared-step
// restoring dividers, atlas address products and the output register.
// Depends on vmmn_pkg.
module vmmn_datapath #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int MAX_TILES  = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  vmmn_pkg::vmmn_cmd_t                 cmd_i,
  output vmmn_pkg::vmmn_stat_t                stat_o,
  input  logic                                cfg_valid_i,
  input  logic [vmmn_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [vmmn_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic [vmmn_pkg::IN_DATA_W-1:0]      in_data_i,
  input  logic [vmmn_pkg::IN_USER_W-1:0]      in_user_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [vmmn_pkg::OUT_DATA_W-1:0]     out_data_o
);

  localparam int VW  = vmmn_pkg::VAL_W;
  localparam int CW  = vmmn_pkg::COORD_W;
  localparam int DW  = vmmn_pkg::DIM_W;
  localparam int TW  = vmmn_pkg::TILE_W;
  localparam int NS  = vmmn_pkg::DIV_STEPS;
  localparam int ROW_W  = CW + DW + 1;
  localparam int COL_W  = TW + DW + 1;
  localparam int AREA_W = TW + DW;
  localparam int PROD_W = ROW_W + AREA_W;

  // clamp limits and clamped reset values
  localparam logic [DW+1:0] MaxW = (DW+2)'(MAX_WIDTH);
  localparam logic [DW+1:0] MaxH = (DW+2)'(MAX_HEIGHT);
  localparam logic [TW:0]   MaxT = (TW+1)'(MAX_TILES);
  localparam logic [DW-1:0] WReset = (vmmn_pkg::WIDTH_RESET > MAX_WIDTH) ?
                                     DW'(MAX_WIDTH) : DW'(vmmn_pkg::WIDTH_RESET);
  localparam logic [DW-1:0] HReset = (vmmn_pkg::HEIGHT_RESET > MAX_HEIGHT) ?
                                     DW'(MAX_HEIGHT) : DW'(vmmn_pkg::HEIGHT_RESET);
  localparam logic [TW-1:0] TReset = (vmmn_pkg::TILES_RESET > MAX_TILES) ?
                                     TW'(MAX_TILES) : TW'(vmmn_pkg::TILES_RESET);

  // ---------------------------------------------------------------- config
  logic [DW-1:0] width_q, height_q;
  logic [TW-1:0] tiles_q;
  logic [DW-1:0] width_c, height_c;
  logic [TW-1:0] tiles_c;

  // registers hold the effective (clamped) values
  always_comb begin
    if (cfg_data_i == '0)                  width_c = DW'(1);
    else if ({2'b00, cfg_data_i} > MaxW)   width_c = MaxW[DW-1:0];
    else                                   width_c = cfg_data_i;
    if (cfg_data_i == '0)                  height_c = DW'(1);
    else if ({2'b00, cfg_data_i} > MaxH)   height_c = MaxH[DW-1:0];
    else                                   height_c = cfg_data_i;
    if (cfg_data_i[TW-1:0] == '0)                  tiles_c = TW'(1);
    else if ({1'b0, cfg_data_i[TW-1:0]} > MaxT)    tiles_c = MaxT[TW-1:0];
    else                                           tiles_c = cfg_data_i[TW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WReset;
      height_q <= HReset;
      tiles_q  <= TReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        vmmn_pkg::REG_SLICE_WIDTH:   width_q  <= width_c;
        vmmn_pkg::REG_SLICE_HEIGHT:  height_q <= height_c;
        vmmn_pkg::REG_TILES_PER_ROW: tiles_q  <= tiles_c;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------- input fields
  logic signed [VW-1:0] v_in;
  logic [CW-1:0] x_in, y_in, z_in;
  logic start_in;

  assign v_in     = $signed(in_data_i[VW-1:0]);
  assign x_in     = in_data_i[VW +: CW];
  assign y_in     = in_data_i[VW+CW +: CW];
  assign z_in     = in_data_i[VW+2*CW +: CW];
  assign start_in = in_user_i[1];

  // ------------------------------------------------------ min/max tracking
  logic signed [VW-1:0] low_q, high_q, low_d, high_d, low_base, high_base;

  always_comb begin
    low_base  = start_in ? vmmn_pkg::LOW_RESET  : low_q;
    high_base = start_in ? vmmn_pkg::HIGH_RESET : high_q;
    low_d  = low_base;
    high_d = high_base;
    if (!v_in[VW-1]) begin
      if (v_in < low_base)  low_d  = v_in;
      if (v_in > high_base) high_d = v_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q  <= vmmn_pkg::LOW_RESET;
      high_q <= vmmn_pkg::HIGH_RESET;
    end else if (cmd_i.measure) begin
      low_q  <= low_d;
      high_q <= high_d;
    end
  end

  // ------------------------------------------------------------- emit load
  logic signed [VW:0] diff_c, range_c;
  logic signed [VW:0] diff_q, range_q;
  logic [VW-1:0] lrem_q, lquo_q;   // level divider remainder and quotient
  logic [TW-1:0] zrem_q;           // slice divider remainder
  logic [NS-1:0] zsh_q;            // slice index shifting out, quotient in
  logic [CW-1:0] x_q, y_q;
  logic [AREA_W-1:0] area_q;       // tiles_per_row * slice_width

  assign diff_c  = {v_in[VW-1], v_in} - {low_q[VW-1], low_q};
  assign range_c = {high_q[VW-1], high_q} - {low_q[VW-1], low_q};

  // divider steps: one quotient bit each for level and for slice row
  logic [VW:0]   lrem_sh;
  logic          lge;
  logic [VW:0]   lrem_sub;
  logic [TW:0]   zrem_sh;
  logic          zge;
  logic [TW:0]   zrem_sub;

  assign lrem_sh  = {lrem_q, 1'b0};
  assign lge      = (lrem_sh >= $unsigned(range_q));
  assign lrem_sub = lrem_sh - $unsigned(range_q);
  assign zrem_sh  = {zrem_q, zsh_q[NS-1]};
  assign zge      = (zrem_sh >= {1'b0, tiles_q});
  assign zrem_sub = zrem_sh - {1'b0, tiles_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      diff_q  <= diff_c;
      range_q <= range_c;
      lrem_q  <= diff_c[VW-1:0];
      lquo_q  <= '0;
      zrem_q  <= '0;
      zsh_q   <= {{(NS-CW){1'b0}}, z_in};
      x_q     <= x_in;
      y_q     <= y_in;
      area_q  <= AREA_W'(tiles_q) * AREA_W'(width_q);
    end else if (cmd_i.step) begin
      lrem_q  <= lge ? lrem_sub[VW-1:0] : lrem_sh[VW-1:0];
      lquo_q  <= {lquo_q[VW-2:0], lge};
      zrem_q  <= zge ? zrem_sub[TW-1:0] : zrem_sh[TW-1:0];
      zsh_q   <= {zsh_q[NS-2:0], zge};
    end
  end

  // ------------------------------------------------------ address products
  logic [ROW_W-1:0] row_q;
  logic [COL_W-1:0] col_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul1) begin
      row_q <= ROW_W'(zsh_q[CW-1:0]) * ROW_W'(height_q) + ROW_W'(y_q);
      col_q <= COL_W'(zrem_q) * COL_W'(width_q) + COL_W'(x_q);
    end
  end

  logic [PROD_W-1:0] prod_c;
  logic [vmmn_pkg::ADDR_W-1:0] addr_c;
  logic [vmmn_pkg::LEVEL_W-1:0] level_c;

  assign prod_c = PROD_W'(row_q) * PROD_W'(area_q);
  assign addr_c = prod_c[vmmn_pkg::ADDR_W-1:0] + vmmn_pkg::ADDR_W'(col_q);

  // saturating cases around the divider quotient
  always_comb begin
    priority if (range_q <= 0)    level_c = vmmn_pkg::LEVEL_ZERO;
    else if (diff_q <= 0)         level_c = vmmn_pkg::LEVEL_ZERO;
    else if (diff_q >= range_q)   level_c = vmmn_pkg::LEVEL_ONE;
    else                          level_c = {1'b0, lquo_q};
  end

  // ------------------------------------------------------- output register
  logic out_valid_q;
  logic [vmmn_pkg::OUT_DATA_W-1:0] out_data_q;

  assign stat_o.out_free = ~out_valid_q | out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_data_q <= {1'b0, addr_c, level_c};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ----- sv/volume_min_max_normalize_to_atlas_unit.sv -----
// Top level of the volume min/max normalizer with slice-mosaic addressing.
// Depends on vmmn_pkg, vmmn_ctrl and vmmn_datapath.
//
// Usage: voxels arrive on the s_axis stream, tuser[0] selecting measure (0)
// or emit (1) pass, tuser[1] restarting min/max tracking on a measure voxel.
// A measure voxel updates the tracked range and is taken every cycle while no
// emit request is in progress; it gives no output. An emit voxel gives one
// m_axis result holding its level (UQ1.16) and its texel index in the atlas.
// An emit request runs as one load, 16 steps of the bit-serial level divider
// (the slice row/column divide shares those steps), the row and column
// products and the final product. The input is not ready until the final
// product has gone into the output register, from which the result shows
// on m_axis.
// The result sits in an output register: the next request is taken while it
// waits, and a stalled receiver only holds the block in its last step once
// a second result is ready.
// The cfg channel writes slice_width, slice_height and tiles_per_row at any
// cycle (always ready); write only while idle. Reset clears the range to
// empty and loads the default geometry; no result is pending after it.
module volume_min_max_normalize_to_atlas_unit #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int MAX_TILES  = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration writes
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [vmmn_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [vmmn_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  // voxel input stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // tdata: voxel_value[15:0], voxel_x[25:16], voxel_y[35:26], voxel_z[45:36], 0
  input  logic [vmmn_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // tuser: func[0], start_flag[1]
  input  logic [vmmn_pkg::IN_USER_W-1:0]      s_axis_tuser,
  // result stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // tdata: level[16:0], atlas_address[46:17], 0
  output logic [vmmn_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

  vmmn_pkg::vmmn_cmd_t  cmd;
  vmmn_pkg::vmmn_stat_t stat;

  assign cfg_ready_o = 1'b1;

  vmmn_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_func_i  (s_axis_tuser[0]),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  vmmn_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_TILES  (MAX_TILES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (s_axis_tdata),
    .in_user_i   (s_axis_tuser),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule

// ----- sv/vmmn_checker.sv -----
// Port-level checks of the normalizer, bound to the top level.
// Depends on vmmn_pkg and the defines header.
`include "volume_min_max_normalize_to_atlas_unit_defines.svh"

module vmmn_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               s_axis_tvalid,
  input logic                               s_axis_tready,
  input logic [vmmn_pkg::IN_USER_W-1:0]     s_axis_tuser,
  input logic                               m_axis_tvalid,
  input logic                               m_axis_tready,
  input logic [vmmn_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

  // a stalled result keeps its valid and payload
  `VMMN_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
                    m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

  // an emit request occupies the block for the following cycles
  `VMMN_ASSERT_NEXT(a_emit_busy, s_axis_tvalid && s_axis_tready && s_axis_tuser[0],
                    !s_axis_tready, "input ready right after emit request")

  // a measure request does not block the next one
  `VMMN_ASSERT_NEXT(a_measure_free, s_axis_tvalid && s_axis_tready && !s_axis_tuser[0],
                    s_axis_tready, "input stalled after measure request")

  // level never exceeds 1.0
  `VMMN_ASSERT_NOW(a_level_range, m_axis_tvalid,
                   !(m_axis_tdata[16] && (m_axis_tdata[15:0] != 16'h0000)),
                   "level above 1.0")

endmodule

bind volume_min_max_normalize_to_atlas_unit vmmn_checker u_vmmn_checker (.*);

// ----- tb/vmmn_tb_pkg.sv -----
// Testbench codes for the volume normalizer: the voxel pass select, the spare
// register index and the geometry limits. Depends on vmmn_pkg.
package vmmn_tb_pkg;
  import vmmn_pkg::*;

  typedef enum logic {
    FUNC_MEASURE = 1'b0,
    FUNC_EMIT    = 1'b1
  } voxel_func_e;

  // index with no register behind it; writes to it must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  localparam int GEOM_MAX_W = 1024;
  localparam int GEOM_MAX_H = 1024;
  localparam int GEOM_MAX_T = 32;

endpackage

// ----- tb/vmmn_texel_checker.sv -----
// Checker for the volume normalizer: tracks geometry and min/max from the
// request channels, predicts level and atlas address, compares results.
// Depends on vmmn_pkg and vmmn_tb_pkg.
module vmmn_texel_checker
  import vmmn_pkg::*;
  import vmmn_tb_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  // tdata: voxel_value, voxel_x, voxel_y, voxel_z, zero pad
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // tuser: func, start_flag
  input  logic [IN_USER_W-1:0]  s_axis_tuser,
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // tdata: level, atlas_address, zero pad
  input  logic [OUT_DATA_W-1:0] m_axis_tdata,
  output int                    fail_count_o,
  output int                    pending_o,
  output int                    results_o
);

  typedef struct {
    logic [LEVEL_W-1:0] level;
    logic [ADDR_W-1:0]  address;
  } texel_t;

  texel_t expected_texels[$];

  // shadow of the geometry registers and the tracked range
  logic [DIM_W-1:0]        width_q;
  logic [DIM_W-1:0]        height_q;
  logic [TILE_W-1:0]       tiles_q;
  logic signed [VAL_W-1:0] lowest_q;
  logic signed [VAL_W-1:0] highest_q;

  // zero acts as one, large values saturate
  function automatic longint unsigned effective_dim(longint unsigned v, longint unsigned top);
    if (v == 0) return 1;
    if (v > top) return top;
    return v;
  endfunction

  // (v - min) / (max - min) in UQ1.16, truncated and clamped
  function automatic logic [LEVEL_W-1:0] normalized_level(logic signed [VAL_W-1:0] v);
    longint offset;
    longint span;
    if (highest_q <= lowest_q) return LEVEL_ZERO;
    offset = longint'(v) - longint'(lowest_q);
    span   = longint'(highest_q) - longint'(lowest_q);
    if (offset <= 0) return LEVEL_ZERO;
    if (offset >= span) return LEVEL_ONE;
    return LEVEL_W'((offset * 65536) / span);
  endfunction

  // slices laid out as tiles, tiles_per_row side by side
  function automatic logic [ADDR_W-1:0] atlas_index(longint unsigned x, longint unsigned y,
                                                    longint unsigned z);
    longint unsigned w;
    longint unsigned h;
    longint unsigned t;
    longint unsigned row;
    longint unsigned col;
    w   = effective_dim(width_q, GEOM_MAX_W);
    h   = effective_dim(height_q, GEOM_MAX_H);
    t   = effective_dim(tiles_q, GEOM_MAX_T);
    row = (z / t) * h + y;
    col = (z % t) * w + x;
    return ADDR_W'(row * t * w + col);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    texel_t                  got;
    texel_t                  want;
    logic signed [VAL_W-1:0] sample;
    if (!rst_ni) begin
      width_q   = DIM_W'(WIDTH_RESET);
      height_q  = DIM_W'(HEIGHT_RESET);
      tiles_q   = TILE_W'(TILES_RESET);
      lowest_q  = LOW_RESET;
      highest_q = HIGH_RESET;
      expected_texels.delete();
      pending_o = 0;
    end else begin
      // register writes
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_SLICE_WIDTH:   width_q  = cfg_data_i;
          REG_SLICE_HEIGHT:  height_q = cfg_data_i;
          REG_TILES_PER_ROW: tiles_q  = cfg_data_i[TILE_W-1:0];
          default: ;
        endcase
      end

      // result compare against the oldest prediction
      if (m_axis_tvalid && m_axis_tready) begin
        got.level   = m_axis_tdata[LEVEL_W-1:0];
        got.address = m_axis_tdata[LEVEL_W +: ADDR_W];
        results_o++;
        if (expected_texels.size() == 0) begin
          fail_count_o++;
          $display("%0t: unexpected result, level %h address %h", $time,
                   got.level, got.address);
        end else begin
          want = expected_texels.pop_front();
          if (got.level !== want.level) begin
            fail_count_o++;
            $display("%0t: level mismatch, expected %h actual %h", $time,
                     want.level, got.level);
          end
          if (got.address !== want.address) begin
            fail_count_o++;
            $display("%0t: atlas_address mismatch, expected %h actual %h", $time,
                     want.address, got.address);
          end
        end
      end

      // accepted voxel request
      if (s_axis_tvalid && s_axis_tready) begin
        sample = s_axis_tdata[VAL_W-1:0];
        if (voxel_func_e'(s_axis_tuser[0]) == FUNC_MEASURE) begin
          if (s_axis_tuser[1]) begin
            lowest_q  = LOW_RESET;
            highest_q = HIGH_RESET;
          end
          // negative samples do not take part in the range
          if (!sample[VAL_W-1]) begin
            if (sample > highest_q) highest_q = sample;
            if (sample < lowest_q) lowest_q = sample;
          end
        end else begin
          want.level   = normalized_level(sample);
          want.address = atlas_index(s_axis_tdata[16 +: COORD_W],
                                     s_axis_tdata[26 +: COORD_W],
                                     s_axis_tdata[36 +: COORD_W]);
          expected_texels = {expected_texels, want};
        end
      end
      pending_o = expected_texels.size();
    end
  end

endmodule

// ----- tb/volume_min_max_normalize_to_atlas_unit_test.sv -----
// Testbench top for volume_min_max_normalize_to_atlas_unit: drives voxel and
// register requests with random gaps and stalls, and gives the verdict.
// Depends on vmmn_pkg, vmmn_tb_pkg, the block and vmmn_texel_checker.
module volume_min_max_normalize_to_atlas_unit_test;
  import vmmn_pkg::*;
  import vmmn_tb_pkg::*;

  localparam int DRAIN_CYCLES  = 24;
  localparam int SEGMENTS      = 8;
  localparam int SEGMENT_ITEMS = 110;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic [IN_USER_W-1:0]  s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  int mismatches;
  int outstanding;
  int results_seen;
  int voxels_sent;
  int reg_writes;
  int send_idle_pct;
  int recv_stall_pct;
  int cur_w;
  int cur_h;

  volume_min_max_normalize_to_atlas_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  vmmn_texel_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fail_count_o  (mismatches),
    .pending_o     (outstanding),
    .results_o     (results_seen)
  );

  always #4 clk_i = ~clk_i;

  // receiver stalls at random
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // hard stop
  initial begin
    #2_000_000;
    $display("FAIL volume_min_max_normalize_to_atlas_unit");
    $finish;
  end

  // one voxel request; entered and left at a falling edge
  task automatic send_voxel(input voxel_func_e func, input logic start,
                            input logic [VAL_W-1:0] value, input logic [COORD_W-1:0] x,
                            input logic [COORD_W-1:0] y, input logic [COORD_W-1:0] z);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= {start, func};
    s_axis_tdata  <= {2'b00, z, y, x, value};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    voxels_sent++;
  endtask

  // stop sending, let every result arrive and the block settle
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    reg_writes++;
  endtask

  // full geometry update plus a write to the unused index
  task automatic write_geometry(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h,
                                input logic [CFG_DATA_W-1:0] t);
    write_reg(REG_SLICE_WIDTH, w);
    write_reg(REG_SLICE_HEIGHT, h);
    write_reg(REG_TILES_PER_ROW, t);
    write_reg(REG_SPARE, CFG_DATA_W'($urandom));
    cfg_valid_i <= 1'b0;
    cur_w = (w == 0) ? 1 : (w > GEOM_MAX_W) ? GEOM_MAX_W : int'(w);
    cur_h = (h == 0) ? 1 : (h > GEOM_MAX_H) ? GEOM_MAX_H : int'(h);
  endtask

  function automatic logic [CFG_DATA_W-1:0] random_reg(input int top);
    case ($urandom_range(7))
      0:       return '0;
      1:       return CFG_DATA_W'($urandom_range(top + 1, 2047));
      2:       return CFG_DATA_W'(top);
      default: return CFG_DATA_W'($urandom_range(1, top));
    endcase
  endfunction

  // measure passes followed by emit passes, with some raw noise between
  task automatic random_segment(input int items);
    int                 target;
    int                 n;
    int                 i;
    int                 base;
    int                 span;
    bit                 empty_pass;
    logic [VAL_W-1:0]   value;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    target = voxels_sent + items;
    while (voxels_sent < target) begin
      if ($urandom_range(9) < 8) begin
        base       = $urandom_range(0, 32767);
        span       = ($urandom_range(3) == 0) ? $urandom_range(0, 32767 - base)
                                              : $urandom_range(0, 64);
        if (base + span > 32767) span = 32767 - base;
        empty_pass = ($urandom_range(15) == 0);
        n = $urandom_range(1, 8);
        for (i = 0; i < n; i++) begin
          if (empty_pass || $urandom_range(7) == 0) value = {1'b1, 15'($urandom)};
          else value = VAL_W'(base + $urandom_range(0, span));
          send_voxel(FUNC_MEASURE, (i == 0) && ($urandom_range(4) != 0), value,
                     COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom));
        end
        n = $urandom_range(1, 8);
        for (i = 0; i < n; i++) begin
          if ($urandom_range(3) != 0) value = VAL_W'(base - 2 + $urandom_range(0, span + 4));
          else value = VAL_W'($urandom);
          x = ($urandom_range(3) == 0) ? COORD_W'($urandom) : COORD_W'($urandom_range(0, cur_w - 1));
          y = ($urandom_range(3) == 0) ? COORD_W'($urandom) : COORD_W'($urandom_range(0, cur_h - 1));
          z = ($urandom_range(1) == 0) ? COORD_W'($urandom_range(0, 40)) : COORD_W'($urandom);
          send_voxel(FUNC_EMIT, 1'($urandom), value, x, y, z);
        end
      end else begin
        send_voxel(voxel_func_e'($urandom_range(1)), 1'($urandom), VAL_W'($urandom),
                   COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom));
      end
    end
  endtask

  initial begin
    int s;
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = '0;
    cfg_data_i     = '0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = '0;
    m_axis_tready  = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    voxels_sent    = 0;
    reg_writes     = 0;
    cur_w          = WIDTH_RESET;
    cur_h          = HEIGHT_RESET;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: empty range, extremes, zero range, restarts, clamping
    send_voxel(FUNC_EMIT, 1'b0, 16'h7FFF, 10'h3FF, 10'h3FF, 10'h3FF);
    send_voxel(FUNC_MEASURE, 1'b1, 16'h8000, 10'h000, 10'h000, 10'h000);
    send_voxel(FUNC_MEASURE, 1'b0, 16'h0000, 10'h000, 10'h000, 10'h000);
    send_voxel(FUNC_MEASURE, 1'b0, 16'h7FFF, 10'h3FF, 10'h3FF, 10'h3FF);
    send_voxel(FUNC_EMIT, 1'b0, 16'h8000, 10'h000, 10'h000, 10'h000);
    send_voxel(FUNC_EMIT, 1'b0, 16'h7FFF, 10'd511, 10'd511, 10'd22);
    send_voxel(FUNC_EMIT, 1'b0, 16'h4000, 10'd3, 10'd4, 10'd23);
    send_voxel(FUNC_EMIT, 1'b0, 16'h0001, 10'd0, 10'd1, 10'd529);
    send_voxel(FUNC_MEASURE, 1'b1, 16'd100, 10'd0, 10'd0, 10'd0);
    send_voxel(FUNC_EMIT, 1'b0, 16'd100, 10'd1, 10'd1, 10'd1);
    send_voxel(FUNC_EMIT, 1'b1, 16'd200, 10'd2, 10'd2, 10'd2);
    send_voxel(FUNC_MEASURE, 1'b0, 16'hFFFF, 10'd0, 10'd0, 10'd0);
    send_voxel(FUNC_MEASURE, 1'b0, 16'd300, 10'd0, 10'd0, 10'd0);
    send_voxel(FUNC_EMIT, 1'b0, 16'd250, 10'd7, 10'd8, 10'd9);
    send_voxel(FUNC_EMIT, 1'b0, 16'd301, 10'd7, 10'd8, 10'd9);
    send_voxel(FUNC_MEASURE, 1'b1, 16'hFFFB, 10'd0, 10'd0, 10'd0);
    send_voxel(FUNC_EMIT, 1'b0, 16'd10, 10'd5, 10'd6, 10'd7);

    // zero registers act as one; a tiles value of 64 keeps only its low bits
    wait_idle();
    write_geometry(11'd0, 11'd0, 11'd64);
    send_voxel(FUNC_MEASURE, 1'b1, 16'd10, 10'd0, 10'd0, 10'd0);
    send_voxel(FUNC_MEASURE, 1'b0, 16'd1000, 10'd0, 10'd0, 10'd0);
    send_voxel(FUNC_EMIT, 1'b0, 16'd500, 10'd5, 10'd7, 10'd9);
    wait_idle();
    write_geometry(11'd0, 11'd0, 11'd0);
    send_voxel(FUNC_EMIT, 1'b0, 16'd999, 10'h3FF, 10'h3FF, 10'h3FF);

    // oversized registers saturate
    wait_idle();
    write_geometry(11'h7FF, 11'h7FF, 11'h7FF);
    send_voxel(FUNC_EMIT, 1'b0, 16'd10, 10'h3FF, 10'h3FF, 10'h3FF);
    send_voxel(FUNC_EMIT, 1'b0, 16'd700, 10'd1, 10'd2, 10'd33);

    // random segments, each with its own geometry and idle mix
    for (s = 0; s < SEGMENTS; s++) begin
      wait_idle();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      case (s)
        0:       write_geometry(11'd1024, 11'd1024, 11'd32);
        1:       write_geometry(11'd1, 11'd1, 11'd1);
        default: write_geometry(random_reg(GEOM_MAX_W), random_reg(GEOM_MAX_H),
                                random_reg(GEOM_MAX_T));
      endcase
      case (s % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 47;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 47;
        end
        default: begin
          send_idle_pct  = 13;
          recv_stall_pct = 13;
        end
      endcase
      random_segment(SEGMENT_ITEMS);
    end

    wait_idle();
    $display("Run: %0d voxel requests, %0d results, %0d register writes,", voxels_sent,
             results_seen, reg_writes);
    $display("over directed edge cases and %0d random segments with mixed gaps and stalls.",
             SEGMENTS);
    if (mismatches == 0 && outstanding == 0) begin
      $display("PASS volume_min_max_normalize_to_atlas_unit");
    end else begin
      $display("FAIL volume_min_max_normalize_to_atlas_unit");
    end
    $finish;
  end

endmodule
